### src/fbpa_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and reset values for the fixed block pool allocator.
// No dependencies.
package fbpa_pkg;

  localparam int NUM_BLOCKS_DEFAULT = 1024;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 32;
  localparam int STRIDE_W   = 17;
  localparam int ALIGN_W    = 13;
  localparam int OFFSET_W   = 12;
  localparam int IDX_W      = 10;
  localparam int TOTAL_W    = 11;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd4;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 17'd64;
  localparam logic [ALIGN_W-1:0]  ALIGN_RESET  = 13'd8;

endpackage

### src/fbpa_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: region size over block stride.
// Depends on fbpa_pkg.
module fbpa_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [fbpa_pkg::SIZE_W-1:0]    dividend,
  input  logic [fbpa_pkg::STRIDE_W-1:0]  divisor,
  output logic                           done,
  output logic [fbpa_pkg::SIZE_W-1:0]    quotient
);
  import fbpa_pkg::*;

  localparam int CNT_W = $clog2(SIZE_W);

  logic                running;
  logic [CNT_W-1:0]    cnt;
  logic [STRIDE_W-1:0] rem;
  logic [STRIDE_W:0]   rem_sh;
  logic                qbit;
  logic [STRIDE_W-1:0] rem_next;

  assign rem_sh   = {rem, quotient[SIZE_W-1]};
  assign qbit     = rem_sh >= {1'b0, divisor};
  assign rem_next = qbit ? STRIDE_W'(rem_sh - {1'b0, divisor}) : STRIDE_W'(rem_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == CNT_W'(SIZE_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      cnt      <= '0;
    end else if (running) begin
      rem      <= rem_next;
      quotient <= {quotient[SIZE_W-2:0], qbit};
      cnt      <= cnt + CNT_W'(1);
    end
  end

endmodule

### src/fixed_block_pool_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the fixed block pool allocator: LIFO free list in a link memory.
// Depends on fbpa_pkg and fbpa_div.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes region_base,
//   region_size, block_stride, alignment and align_offset; always ready.
//   Request beats (req_valid/req_ready) carry operation and block_index; one
//   response beat (rsp_valid/rsp_ready) returns status, given_index,
//   given_address and block_total for every request.
//   Allocate, free and the unused code: one link memory read, then one update
//   of head and memory once the output register is free.
//   Rebuild: the 32-step divider followed by one link memory write per block;
//   a zero stride skips both.
//   req_ready is high only while no request is in progress, so one request
//   is in flight at a time; a response held by a stalled receiver sits in
//   the output register while the next request is accepted, and that
//   request finishes only once the register is taken.
//   Reset empties the pool (count zero, null head) and loads the default
//   configuration; link memory contents are not cleared.
module fixed_block_pool_allocator_top #(
  parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic [fbpa_pkg::OP_W-1:0]        operation,
  input  logic [fbpa_pkg::IDX_W-1:0]       block_index,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output logic                             status,
  output logic [fbpa_pkg::IDX_W-1:0]       given_index,
  output logic [fbpa_pkg::ADDR_W-1:0]      given_address,
  output logic [fbpa_pkg::TOTAL_W-1:0]     block_total
);
  import fbpa_pkg::*;

  localparam int LW = $clog2(NUM_BLOCKS + 1);
  localparam int IW = $clog2(NUM_BLOCKS);
  localparam logic [LW-1:0] NULL_LINK = LW'(NUM_BLOCKS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_LINK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;

  logic [ADDR_W-1:0]   cfg_base;
  logic [SIZE_W-1:0]   cfg_size;
  logic [STRIDE_W-1:0] cfg_stride;
  logic [ALIGN_W-1:0]  cfg_align;
  logic [OFFSET_W-1:0] cfg_offset;

  logic [LW-1:0]     head;
  logic [LW-1:0]     count;
  logic [ADDR_W-1:0] first_addr;
  logic [LW-1:0]     link_i;

  logic [OP_W-1:0]        op;
  logic [IDX_W-1:0]       idx;
  logic [LW+STRIDE_W-1:0] prod;

  logic [LW-1:0] links [NUM_BLOCKS];
  logic [LW-1:0] rd_link;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [LW-1:0] mem_wd;

  logic              out_free;
  logic              rsp_load;
  logic              head_null;
  logic              free_ok;
  logic [LW-1:0]     link_inc;
  logic [ALIGN_W-1:0] align_eff;
  logic [ADDR_W-1:0] align_mask;
  logic [ADDR_W-1:0] start_raw;
  logic [ADDR_W-1:0] start_aligned;

  logic              div_start;
  logic              div_done;
  logic [SIZE_W-1:0] div_q;
  logic [LW-1:0]     count_cap;

  fbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cfg_size),
    .divisor  (cfg_stride),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cfg_ready = 1'b1;
  assign req_ready = state == S_IDLE;
  assign out_free  = !rsp_valid || rsp_ready;
  assign rsp_load  = out_free && ((state == S_EXEC && op != OP_REBUILD) || state == S_DONE);
  assign head_null = head >= NULL_LINK;
  assign free_ok   = 32'(idx) < 32'(count);
  assign link_inc  = link_i + LW'(1);
  assign rd_addr   = head_null ? '0 : IW'(head);
  assign div_start = state == S_EXEC && op == OP_REBUILD && cfg_stride != '0;
  assign count_cap = (div_q > SIZE_W'(NUM_BLOCKS)) ? NULL_LINK : LW'(div_q);

  assign align_eff     = (cfg_align == '0) ? ALIGN_W'(1) : cfg_align;
  assign align_mask    = ADDR_W'(align_eff - ALIGN_W'(1));
  assign start_raw     = cfg_base + ADDR_W'(cfg_offset);
  assign start_aligned = (start_raw + align_mask) & ~align_mask;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = IW'(idx);
    mem_wd = head;
    if (state == S_EXEC && op == OP_FREE && out_free && free_ok) begin
      mem_we = 1'b1;
    end else if (state == S_LINK) begin
      mem_we = 1'b1;
      mem_wa = IW'(link_i);
      mem_wd = (link_inc == count) ? NULL_LINK : link_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      links[mem_wa] <= mem_wd;
    end
    rd_link <= links[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_base   <= '0;
      cfg_size   <= '0;
      cfg_stride <= STRIDE_RESET;
      cfg_align  <= ALIGN_RESET;
      cfg_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE:   cfg_base   <= ADDR_W'(cfg_data);
        REG_SIZE:   cfg_size   <= SIZE_W'(cfg_data);
        REG_STRIDE: cfg_stride <= STRIDE_W'(cfg_data);
        REG_ALIGN:  cfg_align  <= ALIGN_W'(cfg_data);
        REG_OFFSET: cfg_offset <= OFFSET_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      op   <= operation;
      idx  <= block_index;
      prod <= (LW+STRIDE_W)'(head) * (LW+STRIDE_W)'(cfg_stride);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= NULL_LINK;
      count      <= '0;
      first_addr <= '0;
      link_i     <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (op == OP_REBUILD) begin
            first_addr <= start_aligned - ADDR_W'(cfg_offset);
            if (cfg_stride == '0) begin
              count <= '0;
              head  <= NULL_LINK;
              state <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end else if (out_free) begin
            status        <= 1'b0;
            given_index   <= '0;
            given_address <= '0;
            block_total   <= TOTAL_W'(count);
            if (op == OP_ALLOC) begin
              if (head_null) begin
                status <= 1'b1;
              end else begin
                head          <= rd_link;
                given_index   <= IDX_W'(head);
                given_address <= first_addr + ADDR_W'(prod);
              end
            end else if (op == OP_FREE && free_ok) begin
              head <= LW'(idx);
            end
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            count  <= count_cap;
            head   <= (count_cap != '0) ? '0 : NULL_LINK;
            link_i <= '0;
            state  <= (count_cap != '0) ? S_LINK : S_DONE;
          end
        end
        S_LINK: begin
          link_i <= link_inc;
          if (link_inc == count) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            status        <= 1'b0;
            given_index   <= '0;
            given_address <= '0;
            block_total   <= TOTAL_W'(count);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_EXEC || $past(state) == S_DONE))
    else $error("response raised outside a finishing state");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= NULL_LINK)
    else $error("list head beyond null link");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NULL_LINK)
    else $error("block count above pool size");

  a_link_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_LINK |-> link_i < count)
    else $error("link walk past block count");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> given_index == '0 && given_address == '0)
    else $error("failed allocate returned a block");

endmodule
